### src/tta_pkg.sv
`timescale 1ns / 1ps

package tta_pkg;

	// Four pixel lanes, each in a 16-bit slot of the 64-bit lane words.
	localparam int LANES     = 4;
	localparam int LANE_SLOT = 16;
	localparam int WORD_W    = LANES * LANE_SLOT;

	localparam int CNT_W     = 3;
	localparam int ORDER_W   = 2;
	localparam int GAMMA_W   = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = GAMMA_W;
	localparam int ACC_W     = 64;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DIFF_ORDER = 2'd0,
		REG_DOWNSAMPLE = 2'd1,
		REG_GAMMA      = 2'd2
	} cfg_idx_t;

	localparam logic [ORDER_W-1:0] ORDER_RST = 2'd1;
	localparam logic               DS_RST    = 1'b0;
	localparam logic [GAMMA_W-1:0] GAMMA_RST = 8'd2;

endpackage

### src/temporal_activity_accumulator.sv
`timescale 1ns / 1ps

// Temporal activity accumulator. Each beat on the input carries four pixel
// lanes from the current frame and the two frames before it; the block adds
// the absolute first- or second-order temporal difference of the valid lanes
// (or, in downsample mode, of the 2x2 group sum) into a 64-bit accumulator,
// and on the beat marked last it emits gamma times the total and clears it.
// An input beat can be taken every clock cycle unless a stalled output
// holds back a beat marked last. The work runs through four registers: an
// input register, a register holding the item's difference sum, a register
// holding the finished total and the output register that follows the
// gamma multiply. Beats that carry no last mark leave the pipeline at the
// accumulator and never occupy the output side, and a waiting result holds
// only the final stages while beats without the last mark keep flowing
// into the accumulator; a beat marked last waits behind it.
module temporal_activity_accumulator #(
	parameter int LANE_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,

	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [tta_pkg::WORD_W-1:0]      cur_lanes,
	input  logic [tta_pkg::WORD_W-1:0]      prev_lanes,
	input  logic [tta_pkg::WORD_W-1:0]      prev2_lanes,
	input  logic [tta_pkg::CNT_W-1:0]       lane_count,
	input  logic                            last_group,

	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [tta_pkg::ACC_W-1:0]       activity,

	input  logic                            cfg_we,
	input  logic [tta_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tta_pkg::CFG_DATA_W-1:0]  cfg_data
);

	import tta_pkg::*;

	// Signed width of one lane difference, and unsigned width of one item's sum.
	localparam int DIFF_W  = LANE_BITS + 2;
	localparam int MAG_W   = LANE_BITS + 1;
	localparam int GROUP_W = LANE_BITS + 4;
	localparam int ADD_W   = LANE_BITS + 3;
	localparam int PROD_W  = ACC_W + GAMMA_W;

	// Configuration registers
	logic [ORDER_W-1:0] diff_order_q;
	logic               downsample_q;
	logic [GAMMA_W-1:0] gamma_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diff_order_q <= ORDER_RST;
			downsample_q <= DS_RST;
			gamma_q      <= GAMMA_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				REG_DIFF_ORDER: diff_order_q <= cfg_data[ORDER_W-1:0];
				REG_DOWNSAMPLE: downsample_q <= cfg_data[0];
				REG_GAMMA:      gamma_q      <= cfg_data[GAMMA_W-1:0];
				default: ;
			endcase
		end
	end

	// Pipeline control
	logic valid_s1, valid_s2, valid_s3, out_valid_q;
	logic last_s1, last_s2;
	logic ready_out, ready_s3, fire_s2, ready_s2, ready_s1;

	assign ready_out = !out_valid_q || !out_stall;
	assign ready_s3  = !valid_s3 || ready_out;
	// A beat without the last mark only updates the accumulator, so it never waits.
	assign fire_s2   = valid_s2 && (!last_s2 || ready_s3);
	assign ready_s2  = !valid_s2 || fire_s2;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign in_stall  = !ready_s1;

	// Stage 1: input register
	logic [WORD_W-1:0] cur_s1, prev_s1, prev2_s1;
	logic [CNT_W-1:0]  count_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			cur_s1   <= cur_lanes;
			prev_s1  <= prev_lanes;
			prev2_s1 <= prev2_lanes;
			count_s1 <= lane_count;
			last_s1  <= last_group;
		end
	end

	// Difference and absolute sum for the item held in stage 1
	logic [ADD_W-1:0] item_add;

	always_comb begin
		logic signed [DIFF_W-1:0]  c, p, p2, d;
		logic [MAG_W-1:0]          mag;
		logic [ADD_W-1:0]          lane_sum;
		logic signed [GROUP_W-1:0] group;
		logic [GROUP_W-1:0]        group_abs;
		logic                      second;

		second   = diff_order_q[1];
		lane_sum = '0;
		group    = '0;
		for (int i = 0; i < LANES; i++) begin
			c  = $signed({2'b00, cur_s1[i*LANE_SLOT +: LANE_BITS]});
			p  = $signed({2'b00, prev_s1[i*LANE_SLOT +: LANE_BITS]});
			p2 = $signed({2'b00, prev2_s1[i*LANE_SLOT +: LANE_BITS]});
			if (second)
				d = c - (p <<< 1) + p2;
			else
				d = c - p;
			mag = d[DIFF_W-1] ? MAG_W'(-d) : MAG_W'(d);
			// Lane counts above four still enable every lane.
			if (count_s1 > CNT_W'(i))
				lane_sum = lane_sum + ADD_W'(mag);
			group = group + GROUP_W'(d);
		end
		group_abs = group[GROUP_W-1] ? GROUP_W'(-group) : GROUP_W'(group);
		item_add  = downsample_q ? group_abs[ADD_W-1:0] : lane_sum;
	end

	// Stage 2: item sum, then the accumulator update
	logic [ADD_W-1:0] add_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			add_s2  <= item_add;
			last_s2 <= last_s1;
		end
	end

	logic [ACC_W-1:0] activity_sum_q;
	logic [ACC_W-1:0] total;
	logic [ACC_W-1:0] total_s3;

	assign total = activity_sum_q + ACC_W'(add_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			activity_sum_q <= '0;
		end else if (fire_s2) begin
			activity_sum_q <= last_s2 ? '0 : total;
		end
	end

	// Stage 3: finished total of a block, waiting for the gain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s3) begin
			valid_s3 <= fire_s2 && last_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && fire_s2 && last_s2)
			total_s3 <= total;
	end

	// Output register after the gamma multiply, wrapping modulo 2^64
	logic [PROD_W-1:0] product;
	logic [ACC_W-1:0]  activity_q;

	assign product = PROD_W'(total_s3) * PROD_W'(gamma_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ready_out) begin
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_out && valid_s3)
			activity_q <= product[ACC_W-1:0];
	end

	assign out_valid = out_valid_q;
	assign activity  = activity_q;

endmodule
